// ===== rtl/okt_pkg.sv =====
// shared types and codes for the ordered keyed entry table
package okt_pkg;

  localparam int IdW  = 16;
  localparam int PriW = 16;

  // operation codes carried on opcode_i
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_SETPRI = 3'd3;
  localparam logic [2:0] OP_LIST   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [PriW-1:0] pri;
  } entry_t;

  // what a cell does at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SETPRI,
    CELL_NEXT,
    CELL_WRAP
  } cell_op_e;

endpackage

// ===== rtl/okt_cell.sv =====
// one storage cell of the entry chain: holds an entry and compares its id
module okt_cell (
  input  logic                      clk_i,
  input  okt_pkg::cell_op_e         op_i,
  input  okt_pkg::entry_t           load_i,
  input  okt_pkg::entry_t           next_i,
  input  okt_pkg::entry_t           wrap_i,
  input  logic [okt_pkg::IdW-1:0]   key_i,
  output okt_pkg::entry_t           entry_o,
  output logic                      match_o
);

  okt_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      okt_pkg::CELL_HOLD:   entry_d = entry_q;
      okt_pkg::CELL_LOAD:   entry_d = load_i;
      okt_pkg::CELL_SETPRI: entry_d.pri = load_i.pri;
      okt_pkg::CELL_NEXT:   entry_d = next_i;
      okt_pkg::CELL_WRAP:   entry_d = wrap_i;
      default:              entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.id == key_i);

endmodule

// ===== rtl/okt_sel.sv =====
// first-match select: one-hot of the first hit, shift mask and selected entry
module okt_sel #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0]  match_i,
  input  okt_pkg::entry_t   ent_i [DEPTH],
  output logic              found_o,
  output logic [DEPTH-1:0]  first_o,
  output logic [DEPTH-1:0]  from_o,
  output okt_pkg::entry_t   sel_o
);

  logic [DEPTH-1:0] upto;

  // ones at and below the lowest set bit
  assign upto    = match_i ^ (match_i - DEPTH'(1));
  assign first_o = match_i & upto;
  assign from_o  = ~upto | first_o;
  assign found_o = |match_i;

  always_comb begin
    sel_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_o[i]) begin
        sel_o = sel_o | ent_i[i];
      end
    end
  end

endmodule

// ===== rtl/ordered_keyed_entry_table_top.sv =====
// top level of the ordered keyed entry table: cell chain, count and sequencer
//
//  channel   direction  handshake             fields
//  command   in         start & !busy         opcode_i, key_id_i, priority_value_i
//  result    out        res_valid_o (1 cycle) status_o, out_id_o, out_priority_o,
//                                             last_item_o
//
// insert keeps busy low and its result shows the cycle after it is accepted
// remove, lookup and set priority: compare in every cell at accept,
// then first-hit select, update and result in the resolve cycle
// list reports one entry per beat: the chain rotates by one each cycle and
// cell 0 is reported, so after count beats the order is back as it was
// reset clears the count and the sequencer; cell contents are not cleared
// the receiver cannot stall, each result beat lasts exactly one cycle
module ordered_keyed_entry_table_top #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       opcode_i,
  input  logic [okt_pkg::IdW-1:0]          key_id_i,
  input  logic signed [okt_pkg::PriW-1:0]  priority_value_i,
  output logic                             res_valid_o,
  output logic [1:0]                       status_o,
  output logic [okt_pkg::IdW-1:0]          out_id_o,
  output logic signed [okt_pkg::PriW-1:0]  out_priority_o,
  output logic                             last_item_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RESOLVE = 2'd1;
  localparam logic [1:0] S_LIST    = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cnt_m1;
  logic [IdxW-1:0] n_q, n_d;
  logic [2:0]      op_q;
  logic signed [okt_pkg::PriW-1:0] pri_q;
  logic [DEPTH-1:0] hit_q, hit_d;

  logic            rv_q, rv_d;
  logic [1:0]      st_q, st_d;
  logic            last_q, last_d;
  okt_pkg::entry_t res_q, res_d;

  okt_pkg::entry_t   ent   [DEPTH];
  okt_pkg::entry_t   nxt   [DEPTH];
  okt_pkg::cell_op_e cop   [DEPTH];
  logic [DEPTH-1:0]  cmatch;
  okt_pkg::entry_t   load;

  logic             found;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] from;
  okt_pkg::entry_t  sel;

  logic accept;
  logic full;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign full   = (count_q == CntW'(DEPTH));
  assign cnt_m1 = count_q - CntW'(1);

  // load bus: command fields at accept, held priority during resolve
  always_comb begin
    load.id  = key_id_i;
    load.pri = priority_value_i;
    if (state_q != S_IDLE) begin
      load.pri = pri_q;
    end
  end

  // the cell chain; the last cell hands itself back when shifting
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_mid
      assign nxt[i] = ent[i+1];
    end else begin : g_end
      assign nxt[i] = ent[i];
    end

    okt_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cop[i]),
      .load_i  (load),
      .next_i  (nxt[i]),
      .wrap_i  (ent[0]),
      .key_i   (key_id_i),
      .entry_o (ent[i]),
      .match_o (cmatch[i])
    );

    // hit only on occupied cells
    assign hit_d[i] = cmatch[i] && (CntW'(i) < count_q);

    always_comb begin
      cop[i] = okt_pkg::CELL_HOLD;
      case (state_q)
        S_IDLE: begin
          if (accept && opcode_i == okt_pkg::OP_INSERT && !full
              && CntW'(i) == count_q) begin
            cop[i] = okt_pkg::CELL_LOAD;
          end
        end
        S_RESOLVE: begin
          if (found && op_q == okt_pkg::OP_REMOVE && from[i]) begin
            cop[i] = okt_pkg::CELL_NEXT;
          end else if (found && op_q == okt_pkg::OP_SETPRI && first[i]) begin
            cop[i] = okt_pkg::CELL_SETPRI;
          end
        end
        S_LIST: begin
          // rotate the occupied part of the chain by one
          if (CntW'(i) < cnt_m1) begin
            cop[i] = okt_pkg::CELL_NEXT;
          end else if (CntW'(i) == cnt_m1) begin
            cop[i] = okt_pkg::CELL_WRAP;
          end
        end
        default: cop[i] = okt_pkg::CELL_HOLD;
      endcase
    end
  end

  okt_sel #(
    .DEPTH (DEPTH)
  ) u_sel (
    .match_i (hit_q),
    .ent_i   (ent),
    .found_o (found),
    .first_o (first),
    .from_o  (from),
    .sel_o   (sel)
  );

  // sequencer and result beat
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    rv_d    = 1'b0;
    st_d    = okt_pkg::ST_OK;
    last_d  = 1'b1;
    res_d   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            okt_pkg::OP_INSERT: begin
              rv_d = 1'b1;
              if (full) begin
                st_d = okt_pkg::ST_FULL;
              end else begin
                res_d   = load;
                count_d = count_q + CntW'(1);
              end
            end
            okt_pkg::OP_REMOVE,
            okt_pkg::OP_LOOKUP,
            okt_pkg::OP_SETPRI: begin
              state_d = S_RESOLVE;
            end
            okt_pkg::OP_LIST: begin
              if (count_q == '0) begin
                rv_d = 1'b1;
                st_d = okt_pkg::ST_EMPTY;
              end else begin
                state_d = S_LIST;
                n_d     = '0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RESOLVE: begin
        rv_d    = 1'b1;
        state_d = S_IDLE;
        if (!found) begin
          if (op_q == okt_pkg::OP_REMOVE && count_q == '0) begin
            st_d = okt_pkg::ST_EMPTY;
          end else begin
            st_d = okt_pkg::ST_NOT_FOUND;
          end
        end else begin
          res_d = sel;
          if (op_q == okt_pkg::OP_SETPRI) begin
            res_d.pri = pri_q;
          end
          if (op_q == okt_pkg::OP_REMOVE) begin
            count_d = cnt_m1;
          end
        end
      end
      S_LIST: begin
        rv_d   = 1'b1;
        res_d  = ent[0];
        last_d = (CntW'(n_q) == cnt_m1);
        n_d    = n_q + IdxW'(1);
        if (last_d) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_q     <= '0;
      rv_q    <= 1'b0;
      hit_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      rv_q    <= rv_d;
      if (accept) begin
        hit_q <= hit_d;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      pri_q <= priority_value_i;
    end
    st_q   <= st_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

  assign res_valid_o    = rv_q;
  assign status_o       = st_q;
  assign out_id_o       = res_q.id;
  assign out_priority_o = res_q.pri;
  assign last_item_o    = last_q;

endmodule

// ===== rtl/okt_chk.sv =====
// port-level checker for the ordered keyed entry table, with its bind
module okt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  opcode_i,
  input logic        res_valid_o,
  input logic [1:0]  status_o,
  input logic [15:0] out_id_o,
  input logic [15:0] out_priority_o,
  input logic        last_item_o
);

  // a searching command always occupies the block for its resolve cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == okt_pkg::OP_REMOVE
      || opcode_i == okt_pkg::OP_LOOKUP || opcode_i == okt_pkg::OP_SETPRI))
    |=> busy)
    else $error("search command did not raise busy");

  // insert answers with a single beat on the next cycle
  a_insert_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == okt_pkg::OP_INSERT)
    |=> (res_valid_o && last_item_o))
    else $error("insert gave no single result beat");

  // a list beat that is not the final one only occurs mid-list
  a_mid_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_item_o) |-> busy)
    else $error("non-final beat outside a list");

  // failure results are single, zero-filled beats
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != okt_pkg::ST_OK)
    |-> (last_item_o && out_id_o == '0 && out_priority_o == '0))
    else $error("failure beat not final or not zero");

endmodule

bind ordered_keyed_entry_table_top okt_chk u_okt_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .res_valid_o    (res_valid_o),
  .status_o       (status_o),
  .out_id_o       (out_id_o),
  .out_priority_o (out_priority_o),
  .last_item_o    (last_item_o)
);
